// File: src/sorted_key_count_table_defines.svh
// assertion macros used by the rtl
`ifndef SORTED_KEY_COUNT_TABLE_DEFINES_SVH
`define SORTED_KEY_COUNT_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SKCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skct check failed");

// next-cycle implication, checked outside reset
`define SKCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("skct check failed");

`endif

// File: src/skct_pkg.sv
`default_nettype none
package skct_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int KEY_BITS      = 32;
    localparam int COUNT_BITS    = 32;
    localparam int POS_BITS      = $clog2(TABLE_ENTRIES + 1);
    localparam int SLOT_BITS     = 7;
    localparam int S_DATA_BITS   = 64;
    localparam int M_DATA_BITS   = 48;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_COMPARE,
        OP_UPDATE,
        OP_INSERT,
        OP_REMOVE
    } cell_op_t;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] count;
    } cell_state_t;

    typedef struct packed {
        cell_op_t              op;
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] count;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GATHER,
        ST_APPLY
    } ctrl_state_t;

endpackage
`default_nettype wire

// File: src/sorted_key_count_table.sv
// channel  | dir | tdata fields, lowest bit first
// s_       | in  | item_key[31:0], count_delta[63:32]
// m_       | out | count_after[31:0], was_present[32], sorted_slot[39:33],
//          |     | table_full_drop[40], count_saturated[41], zero[47:42]
// each word passes through: compare in every cell, reduce the cell flags,
// then add, clamp and update the matching cell or shift the chain of cells by one place
// a new word is taken on the cycle after the result is loaded, even while it waits
// the result register holds while m_tready is low, and the update waits with it
// aresetn clears every cell's valid flag at once, so the table starts empty
`default_nettype none
module sorted_key_count_table (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // item_key, count_delta
    input  wire logic [skct_pkg::S_DATA_BITS-1:0]   s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // count_after, was_present, sorted_slot, table_full_drop, count_saturated
    output logic [skct_pkg::M_DATA_BITS-1:0]        m_tdata
);
    import skct_pkg::*;

    cell_cmd_t                                 cell_cmd;
    cell_state_t [TABLE_ENTRIES-1:0]           states;
    logic [TABLE_ENTRIES-1:0]                  lt_vec;
    logic [TABLE_ENTRIES-1:0]                  eq_vec;
    logic [TABLE_ENTRIES-1:0][COUNT_BITS-1:0]  cell_counts;

    localparam cell_state_t EMPTY_STATE = '{valid: 1'b0, key: '0, count: '0};

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        cell_state_t left_state;
        cell_state_t right_state;
        logic        left_lt;

        if (i == 0) begin : g_first
            assign left_state = EMPTY_STATE;
            assign left_lt    = 1'b1;
        end else begin : g_inner
            assign left_state = states[i-1];
            assign left_lt    = lt_vec[i-1];
        end

        if (i == TABLE_ENTRIES - 1) begin : g_last
            assign right_state = EMPTY_STATE;
        end else begin : g_body
            assign right_state = states[i+1];
        end

        skct_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cell_cmd),
            .left_state  (left_state),
            .left_lt     (left_lt),
            .right_state (right_state),
            .own_state   (states[i]),
            .own_lt      (lt_vec[i]),
            .own_eq      (eq_vec[i])
        );

        assign cell_counts[i] = states[i].count;
    end

    skct_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .lt_vec      (lt_vec),
        .eq_vec      (eq_vec),
        .cell_counts (cell_counts),
        .last_valid  (states[TABLE_ENTRIES-1].valid),
        .cell_cmd    (cell_cmd)
    );

endmodule
`default_nettype wire

// File: src/skct_cell.sv
`default_nettype none
module skct_cell (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire skct_pkg::cell_cmd_t cmd,
    input  wire skct_pkg::cell_state_t left_state,
    input  wire logic                left_lt,
    input  wire skct_pkg::cell_state_t right_state,
    output skct_pkg::cell_state_t    own_state,
    output logic                     own_lt,
    output logic                     own_eq
);
    import skct_pkg::*;

    logic                  valid_reg, valid_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  lt_reg, lt_next;
    logic                  eq_reg, eq_next;

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        count_next = count_reg;
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        case (cmd.op)
            OP_COMPARE: begin
                lt_next = valid_reg && (key_reg < cmd.key);
                eq_next = valid_reg && (key_reg == cmd.key);
            end
            OP_UPDATE: begin
                if (eq_reg) begin
                    count_next = cmd.count;
                end
            end
            OP_INSERT: begin
                if (!lt_reg) begin
                    if (left_lt) begin
                        valid_next = 1'b1;
                        key_next   = cmd.key;
                        count_next = cmd.count;
                    end else begin
                        valid_next = left_state.valid;
                        key_next   = left_state.key;
                        count_next = left_state.count;
                    end
                end
            end
            OP_REMOVE: begin
                if (!lt_reg) begin
                    valid_next = right_state.valid;
                    key_next   = right_state.key;
                    count_next = right_state.count;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            lt_reg    <= lt_next;
            eq_reg    <= eq_next;
        end
        key_reg   <= key_next;
        count_reg <= count_next;
    end

    assign own_state = '{valid: valid_reg, key: key_reg, count: count_reg};
    assign own_lt    = lt_reg;
    assign own_eq    = eq_reg;

endmodule
`default_nettype wire

// File: src/skct_ctrl.sv
`default_nettype none
`include "sorted_key_count_table_defines.svh"
module skct_ctrl (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [skct_pkg::S_DATA_BITS-1:0]      s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [skct_pkg::M_DATA_BITS-1:0]           m_tdata,
    input  wire logic [skct_pkg::TABLE_ENTRIES-1:0]    lt_vec,
    input  wire logic [skct_pkg::TABLE_ENTRIES-1:0]    eq_vec,
    input  wire logic [skct_pkg::TABLE_ENTRIES-1:0][skct_pkg::COUNT_BITS-1:0] cell_counts,
    input  wire logic                                  last_valid,
    output skct_pkg::cell_cmd_t                        cell_cmd
);
    import skct_pkg::*;

    localparam logic [POS_BITS-1:0] POS_ABSENT = POS_BITS'(TABLE_ENTRIES);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic [COUNT_BITS-1:0] COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    ctrl_state_t state_reg, state_next;

    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [COUNT_BITS-1:0] delta_reg, delta_next;
    logic                  present_reg, present_next;
    logic [COUNT_BITS-1:0] hit_reg, hit_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic                  full_reg, full_next;

    logic                  m_valid_reg, m_valid_next;
    logic [COUNT_BITS-1:0] out_count_reg, out_count_next;
    logic                  out_present_reg, out_present_next;
    logic [POS_BITS-1:0]   out_pos_reg, out_pos_next;
    logic                  out_drop_reg, out_drop_next;
    logic                  out_sat_reg, out_sat_next;

    logic                  out_free;
    logic                  accept;
    logic                  load_out;
    logic                  gather_present;
    logic [COUNT_BITS-1:0] gather_hit;
    logic [POS_BITS-1:0]   gather_pos;
    logic [COUNT_BITS:0]   sum_wide;
    logic [COUNT_BITS-1:0] sum_clamped;
    logic                  sum_sat;
    cell_op_t              apply_op;
    logic [COUNT_BITS-1:0] apply_count;
    logic                  apply_present;
    logic [POS_BITS-1:0]   apply_pos;
    logic                  apply_drop;
    logic                  apply_sat;

    assign out_free = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // reduce the cell flags after the compare
    always_comb begin
        gather_present = |eq_vec;
        gather_hit     = '0;
        gather_pos     = POS_ABSENT;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (eq_vec[i]) begin
                gather_hit = gather_hit | cell_counts[i];
            end
            if (!lt_vec[i] && ((i == 0) || lt_vec[(i == 0) ? 0 : i - 1])) begin
                gather_pos = POS_BITS'(i);
            end
        end
    end

    // signed add with clamp
    always_comb begin
        sum_wide = {hit_reg[COUNT_BITS-1], hit_reg} + {delta_reg[COUNT_BITS-1], delta_reg};
        sum_sat  = sum_wide[COUNT_BITS] != sum_wide[COUNT_BITS-1];
        if (sum_sat) begin
            sum_clamped = sum_wide[COUNT_BITS] ? COUNT_MIN : COUNT_MAX;
        end else begin
            sum_clamped = sum_wide[COUNT_BITS-1:0];
        end
    end

    // decide what the table does with this word
    always_comb begin
        apply_op      = OP_HOLD;
        apply_count   = '0;
        apply_present = 1'b0;
        apply_pos     = POS_ABSENT;
        apply_drop    = 1'b0;
        apply_sat     = 1'b0;
        if (key_reg != '0) begin
            apply_present = present_reg;
            if (delta_reg == '0) begin
                if (present_reg) begin
                    apply_count = hit_reg;
                    apply_pos   = pos_reg;
                end
            end else if (present_reg) begin
                apply_sat = sum_sat;
                if (sum_clamped == '0) begin
                    apply_op = OP_REMOVE;
                end else begin
                    apply_op    = OP_UPDATE;
                    apply_count = sum_clamped;
                    apply_pos   = pos_reg;
                end
            end else if (full_reg) begin
                apply_drop = 1'b1;
            end else begin
                apply_op    = OP_INSERT;
                apply_count = delta_reg;
                apply_pos   = pos_reg;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_GATHER;
                end
            end
            ST_GATHER: begin
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_tready       = 1'b0;
        load_out       = 1'b0;
        cell_cmd.op    = OP_HOLD;
        cell_cmd.key   = key_reg;
        cell_cmd.count = apply_count;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cell_cmd.op  = OP_COMPARE;
                    cell_cmd.key = s_tdata[KEY_BITS-1:0];
                end
            end
            ST_GATHER: begin
            end
            ST_APPLY: begin
                if (out_free) begin
                    load_out    = 1'b1;
                    cell_cmd.op = apply_op;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        key_next         = key_reg;
        delta_next       = delta_reg;
        present_next     = present_reg;
        hit_next         = hit_reg;
        pos_next         = pos_reg;
        full_next        = full_reg;
        out_count_next   = out_count_reg;
        out_present_next = out_present_reg;
        out_pos_next     = out_pos_reg;
        out_drop_next    = out_drop_reg;
        out_sat_next     = out_sat_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        if (accept) begin
            key_next   = s_tdata[KEY_BITS-1:0];
            delta_next = s_tdata[32 +: COUNT_BITS];
        end
        if (state_reg == ST_GATHER) begin
            present_next = gather_present;
            hit_next     = gather_hit;
            pos_next     = gather_pos;
            full_next    = last_valid;
        end
        if (load_out) begin
            m_valid_next     = 1'b1;
            out_count_next   = apply_count;
            out_present_next = apply_present;
            out_pos_next     = apply_pos;
            out_drop_next    = apply_drop;
            out_sat_next     = apply_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        key_reg         <= key_next;
        delta_reg       <= delta_next;
        present_reg     <= present_next;
        hit_reg         <= hit_next;
        pos_reg         <= pos_next;
        full_reg        <= full_next;
        out_count_reg   <= out_count_next;
        out_present_reg <= out_present_next;
        out_pos_reg     <= out_pos_next;
        out_drop_reg    <= out_drop_next;
        out_sat_reg     <= out_sat_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, out_sat_reg, out_drop_reg, SLOT_BITS'(out_pos_reg),
                       out_present_reg, out_count_reg};

    `SKCT_ASSERT_NOW(a_eq_onehot, aclk, aresetn, state_reg == ST_GATHER, $onehot0(eq_vec))
    `SKCT_ASSERT_NEXT(a_accept_gather, aclk, aresetn, accept, state_reg == ST_GATHER)
    `SKCT_ASSERT_NOW(a_sat_nonzero, aclk, aresetn, m_valid_reg && out_sat_reg,
                     out_count_reg != '0)
    `SKCT_ASSERT_NOW(a_drop_absent, aclk, aresetn, m_valid_reg && out_drop_reg,
                     !out_present_reg && out_pos_reg == POS_ABSENT)

endmodule
`default_nettype wire
